// ----- src/tte_pkg.sv -----
// Shared package for the tuning table edit engine.
// Holds field widths, command and register codes, reset values, payload types and states.
// No dependencies.
`default_nettype none

package tte_pkg;

   localparam int KEY_W                 = 7;
   localparam int VALUE_W               = 16;
   localparam int LIMIT_W               = 15;
   localparam int OP_W                  = 3;
   localparam int CSR_INDEX_W           = 2;
   localparam int CSR_DATA_W            = 16;
   localparam int FRAC_W                = 16;
   localparam int SLOPE_W               = 32;
   localparam int DEFAULT_TABLE_ENTRIES = 128;

   localparam logic [OP_W-1:0] OP_READ      = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE     = 3'd1;
   localparam logic [OP_W-1:0] OP_TRANSPOSE = 3'd2;
   localparam logic [OP_W-1:0] OP_INCREMENT = 3'd3;
   localparam logic [OP_W-1:0] OP_INTERP    = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_VALUE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH_MAX  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH_MIN  = 2'd2;

   localparam logic signed [VALUE_W-1:0] STEP_RESET      = 16'sd200;
   localparam logic [LIMIT_W-1:0]        PITCH_MAX_RESET = 15'd21920;
   localparam logic [LIMIT_W-1:0]        PITCH_MIN_RESET = 15'd320;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_SHORT = 1'b1;

   // equal temperament in cents; the table holds twice these, in half-cents
   localparam int ET_LOW_KEY     = 21;
   localparam int ET_HIGH_KEY    = 108;
   localparam int ET_REF_KEY     = 12;
   localparam int ET_FLOOR_HC    = 160;
   localparam int ET_CEIL_HC     = 10960;
   localparam int ET_SEMITONE_HC = 100;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic [KEY_W-1:0]          first_key;
      logic [KEY_W-1:0]          second_key;
      logic [KEY_W-1:0]          dest_key;
      logic signed [VALUE_W-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      logic                      status;
   } rsp_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] step_value;
      logic [LIMIT_W-1:0]        pitch_max;
      logic [LIMIT_W-1:0]        pitch_min;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_SNAP,
      ST_XP,
      ST_INC_RD,
      ST_INC_SEED,
      ST_INC,
      ST_IP_RD,
      ST_IP_DIV,
      ST_IP_WAIT,
      ST_IP_FILL
   } state_type;

endpackage

`default_nettype wire

// ----- src/tuning_table_edit_engine_core.sv -----
// Tuning table edit engine top level: control registers, sequencer, divider and table store.
// Depends on tte_pkg, tte_store, tte_div and tte_seq.
//
// A command is taken when start is high and busy is low; each command returns exactly one
// result, shown on rsp_data for a single cycle with rsp_strobe high, and the receiver cannot
// hold it off. After reset, busy stays high while the table is loaded with equal
// temperament. A read passes through ST_DECODE and ST_READ before its result is registered;
// a write is done in ST_DECODE. Edit commands first copy the whole table into the undo
// snapshot, one entry per cycle, then rewrite their range one entry per cycle, interpolate
// only after the slope division. Each memory has a single write port. Control registers
// may be written only while busy is low.
`default_nettype none

module tuning_table_edit_engine_core
   import tte_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire req_type                req_data,
   output logic                        busy,
   output logic                        rsp_strobe,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ADDR_W = $clog2(TABLE_ENTRIES);

   cfg_type             cfg_ff, cfg_in;

   logic                pitch_we;
   logic [ADDR_W-1:0]   pitch_waddr;
   logic [VALUE_W-1:0]  pitch_wdata;
   logic [ADDR_W-1:0]   pitch_raddr;
   logic [VALUE_W-1:0]  pitch_rdata;
   logic                undo_we;
   logic [ADDR_W-1:0]   undo_waddr;
   logic [VALUE_W-1:0]  undo_wdata;
   logic [ADDR_W-1:0]   undo_raddr;
   logic [VALUE_W-1:0]  undo_rdata;
   logic                div_start;
   logic [SLOPE_W-1:0]  div_dividend;
   logic [ADDR_W-1:0]   div_divisor;
   logic                div_done;
   logic [SLOPE_W-1:0]  div_quotient;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_STEP_VALUE: cfg_in.step_value = csr_wdata;
            CSR_PITCH_MAX:  cfg_in.pitch_max  = csr_wdata[LIMIT_W-1:0];
            CSR_PITCH_MIN:  cfg_in.pitch_min  = csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_value <= STEP_RESET;
         cfg_ff.pitch_max  <= PITCH_MAX_RESET;
         cfg_ff.pitch_min  <= PITCH_MIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tte_seq #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ADDR_W        (ADDR_W)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_data     (req_data),
      .busy         (busy),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data),
      .cfg          (cfg_ff),
      .pitch_we     (pitch_we),
      .pitch_waddr  (pitch_waddr),
      .pitch_wdata  (pitch_wdata),
      .pitch_raddr  (pitch_raddr),
      .pitch_rdata  (pitch_rdata),
      .undo_we      (undo_we),
      .undo_waddr   (undo_waddr),
      .undo_wdata   (undo_wdata),
      .undo_raddr   (undo_raddr),
      .undo_rdata   (undo_rdata),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   tte_div #(
      .DIVISOR_W (ADDR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   tte_store #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ADDR_W        (ADDR_W)
   ) u_store (
      .clock       (clock),
      .pitch_we    (pitch_we),
      .pitch_waddr (pitch_waddr),
      .pitch_wdata (pitch_wdata),
      .pitch_raddr (pitch_raddr),
      .pitch_rdata (pitch_rdata),
      .undo_we     (undo_we),
      .undo_waddr  (undo_waddr),
      .undo_wdata  (undo_wdata),
      .undo_raddr  (undo_raddr),
      .undo_rdata  (undo_rdata)
   );

endmodule

`default_nettype wire

// ----- src/tte_store.sv -----
// Pitch table and undo snapshot memories, one write and one registered read port each.
// Depends on tte_pkg.
`default_nettype none

module tte_store
   import tte_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES,
   parameter int ADDR_W        = $clog2(DEFAULT_TABLE_ENTRIES)
) (
   input  wire logic               clock,
   input  wire logic               pitch_we,
   input  wire logic [ADDR_W-1:0]  pitch_waddr,
   input  wire logic [VALUE_W-1:0] pitch_wdata,
   input  wire logic [ADDR_W-1:0]  pitch_raddr,
   output logic      [VALUE_W-1:0] pitch_rdata,
   input  wire logic               undo_we,
   input  wire logic [ADDR_W-1:0]  undo_waddr,
   input  wire logic [VALUE_W-1:0] undo_wdata,
   input  wire logic [ADDR_W-1:0]  undo_raddr,
   output logic      [VALUE_W-1:0] undo_rdata
);

   logic [VALUE_W-1:0] pitch_mem [TABLE_ENTRIES];
   logic [VALUE_W-1:0] undo_mem  [TABLE_ENTRIES];

   always_ff @(posedge clock) begin
      if (pitch_we) begin
         pitch_mem[pitch_waddr] <= pitch_wdata;
      end
      pitch_rdata <= pitch_mem[pitch_raddr];
   end

   always_ff @(posedge clock) begin
      if (undo_we) begin
         undo_mem[undo_waddr] <= undo_wdata;
      end
      undo_rdata <= undo_mem[undo_raddr];
   end

endmodule

`default_nettype wire

// ----- src/tte_div.sv -----
// Restoring divider, one quotient bit per cycle, for the interpolation slope.
// Depends on tte_pkg.
`default_nettype none

module tte_div
   import tte_pkg::*;
#(
   parameter int DIVISOR_W = $clog2(DEFAULT_TABLE_ENTRIES)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [SLOPE_W-1:0]   dividend,
   input  wire logic [DIVISOR_W-1:0] divisor,
   output logic                      done,
   output logic      [SLOPE_W-1:0]   quotient
);

   localparam int                COUNT_W = $clog2(SLOPE_W);
   localparam logic [COUNT_W-1:0] LAST_C = COUNT_W'(SLOPE_W - 1);

   logic                 run_ff,   run_in;
   logic                 done_ff,  done_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [DIVISOR_W-1:0] rem_ff,   rem_in;
   logic [DIVISOR_W-1:0] div_ff,   div_in;
   logic [SLOPE_W-1:0]   quo_ff,   quo_in;
   logic [DIVISOR_W:0]   rem_sh;
   logic [DIVISOR_W:0]   rem_diff;
   logic                 fits;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[SLOPE_W-1]};
      fits     = rem_sh >= {1'b0, div_ff};
      rem_diff = rem_sh - {1'b0, div_ff};
      run_in   = run_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      quo_in   = quo_ff;
      if (start) begin
         run_in   = 1'b1;
         count_in = '0;
         rem_in   = '0;
         div_in   = divisor;
         quo_in   = dividend;
      end else if (run_ff) begin
         rem_in   = fits ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
         quo_in   = {quo_ff[SLOPE_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_C) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      quo_ff   <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- src/tte_seq.sv -----
// Command sequencer: reset fill, snapshot sweep, range rewrites and result transfer.
// Depends on tte_pkg; drives the ports of tte_store and tte_div.
`default_nettype none

module tte_seq
   import tte_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES,
   parameter int ADDR_W        = $clog2(DEFAULT_TABLE_ENTRIES)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire req_type            req_data,
   output logic                    busy,
   output logic                    rsp_strobe,
   output rsp_type                 rsp_data,
   input  wire cfg_type            cfg,
   output logic                    pitch_we,
   output logic      [ADDR_W-1:0]  pitch_waddr,
   output logic      [VALUE_W-1:0] pitch_wdata,
   output logic      [ADDR_W-1:0]  pitch_raddr,
   input  wire logic [VALUE_W-1:0] pitch_rdata,
   output logic                    undo_we,
   output logic      [ADDR_W-1:0]  undo_waddr,
   output logic      [VALUE_W-1:0] undo_wdata,
   output logic      [ADDR_W-1:0]  undo_raddr,
   input  wire logic [VALUE_W-1:0] undo_rdata,
   output logic                    div_start,
   output logic      [SLOPE_W-1:0] div_dividend,
   output logic      [ADDR_W-1:0]  div_divisor,
   input  wire logic               div_done,
   input  wire logic [SLOPE_W-1:0] div_quotient
);

   localparam logic [ADDR_W:0] ENTRIES_C = (ADDR_W + 1)'(TABLE_ENTRIES);
   localparam logic [ADDR_W:0] LAST_C    = (ADDR_W + 1)'(TABLE_ENTRIES - 1);

   function automatic logic [ADDR_W-1:0] key_mod(input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] r;
      r = key;
      for (int s = KEY_W - 1; s >= 0; s--) begin
         if (32'(r) >= (TABLE_ENTRIES << s)) begin
            r = r - KEY_W'(TABLE_ENTRIES << s);
         end
      end
      return ADDR_W'(r);
   endfunction

   function automatic logic [VALUE_W-1:0] et_entry(input logic [ADDR_W:0] idx);
      if (idx < ET_LOW_KEY) begin
         return VALUE_W'(2 * ET_FLOOR_HC);
      end else if (idx > ET_HIGH_KEY) begin
         return VALUE_W'(2 * ET_CEIL_HC);
      end else begin
         return VALUE_W'(idx) * VALUE_W'(2 * ET_SEMITONE_HC)
              - VALUE_W'(2 * (ET_SEMITONE_HC * ET_REF_KEY - ET_FLOOR_HC));
      end
   endfunction

   function automatic logic [VALUE_W-1:0] clamp_pitch(input logic [VALUE_W-1:0] base,
                                                       input cfg_type c);
      logic signed [VALUE_W:0] sum;
      sum = $signed({base[VALUE_W-1], base}) + $signed({c.step_value[VALUE_W-1], c.step_value});
      if (sum > $signed({2'b00, c.pitch_max})) begin
         return {1'b0, c.pitch_max};
      end else if (sum < $signed({2'b00, c.pitch_min})) begin
         return {1'b0, c.pitch_min};
      end else begin
         return sum[VALUE_W-1:0];
      end
   endfunction

   state_type           state_ff, state_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [ADDR_W-1:0]   a_ff, a_in;
   logic [ADDR_W-1:0]   b_ff, b_in;
   logic [ADDR_W-1:0]   d_ff, d_in;
   logic [ADDR_W-1:0]   lo_ff, lo_in;
   logic [ADDR_W-1:0]   hi_ff, hi_in;
   logic [VALUE_W-1:0]  wv_ff, wv_in;
   logic [ADDR_W:0]     cnt_ff, cnt_in;
   logic [ADDR_W:0]     dst_ff, dst_in;
   logic                pend_ff, pend_in;
   logic [ADDR_W-1:0]   pend_dst_ff, pend_dst_in;
   logic [VALUE_W-1:0]  v_ff, v_in;
   logic [SLOPE_W-1:0]  slope_ff, slope_in;
   logic [SLOPE_W-1:0]  acc_ff, acc_in;
   logic                neg_ff, neg_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                fin;
   logic                fin_status;
   logic [VALUE_W-1:0]  fin_value;
   logic [ADDR_W:0]     cnt_dec;
   logic [ADDR_W:0]     hi_dec;
   logic [ADDR_W-1:0]   span;
   logic [VALUE_W-1:0]  inc_value;
   logic signed [VALUE_W:0] diff;
   logic [VALUE_W:0]    diff_mag;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      d_in          = d_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      wv_in         = wv_ff;
      cnt_in        = cnt_ff;
      dst_in        = dst_ff;
      pend_in       = 1'b0;
      pend_dst_in   = pend_dst_ff;
      v_in          = v_ff;
      slope_in      = slope_ff;
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;

      fin        = 1'b0;
      fin_status = STATUS_OK;
      fin_value  = '0;

      cnt_dec   = cnt_ff - 1'b1;
      hi_dec    = {1'b0, hi_ff} - 1'b1;
      span      = hi_ff - lo_ff;
      inc_value = clamp_pitch(v_ff, cfg);
      diff      = $signed({pitch_rdata[VALUE_W-1], pitch_rdata})
                - $signed({undo_rdata[VALUE_W-1], undo_rdata});
      diff_mag  = diff[VALUE_W] ? VALUE_W'(0) - diff : diff;

      pitch_we     = 1'b0;
      pitch_waddr  = '0;
      pitch_wdata  = '0;
      pitch_raddr  = '0;
      undo_we      = 1'b0;
      undo_waddr   = '0;
      undo_wdata   = '0;
      undo_raddr   = '0;
      div_start    = 1'b0;
      div_dividend = {diff_mag[VALUE_W-1:0], {FRAC_W{1'b0}}};
      div_divisor  = span;

      // retire the transpose write issued last cycle
      if (pend_ff) begin
         pitch_we    = 1'b1;
         pitch_waddr = pend_dst_ff;
         pitch_wdata = clamp_pitch(undo_rdata, cfg);
      end

      unique case (state_ff)
         ST_CLEAR: begin
            pitch_we    = 1'b1;
            pitch_waddr = cnt_ff[ADDR_W-1:0];
            pitch_wdata = et_entry(cnt_ff);
            if (cnt_ff == LAST_C) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in    = req_data.op;
               a_in     = key_mod(req_data.first_key);
               b_in     = key_mod(req_data.second_key);
               d_in     = key_mod(req_data.dest_key);
               wv_in    = req_data.write_value;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            lo_in = (a_ff < b_ff) ? a_ff : b_ff;
            hi_in = (a_ff < b_ff) ? b_ff : a_ff;
            unique case (op_ff) inside
               OP_READ: begin
                  pitch_raddr = a_ff;
                  state_in    = ST_READ;
               end
               OP_WRITE: begin
                  pitch_we    = 1'b1;
                  pitch_waddr = a_ff;
                  pitch_wdata = wv_ff;
                  fin         = 1'b1;
               end
               OP_TRANSPOSE, OP_INCREMENT, OP_INTERP: begin
                  cnt_in   = '0;
                  state_in = ST_SNAP;
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end
         ST_READ: begin
            fin       = 1'b1;
            fin_value = pitch_rdata;
         end
         ST_SNAP: begin
            pitch_raddr = cnt_ff[ADDR_W-1:0];
            if (cnt_ff != '0) begin
               undo_we    = 1'b1;
               undo_waddr = cnt_dec[ADDR_W-1:0];
               undo_wdata = pitch_rdata;
            end
            if (cnt_ff == ENTRIES_C) begin
               unique case (op_ff) inside
                  OP_TRANSPOSE: begin
                     cnt_in   = {1'b0, lo_ff};
                     dst_in   = {1'b0, d_ff};
                     state_in = ST_XP;
                  end
                  OP_INCREMENT: begin
                     if (lo_ff == hi_ff) begin
                        fin        = 1'b1;
                        fin_status = STATUS_SHORT;
                     end else begin
                        state_in = ST_INC_RD;
                     end
                  end
                  OP_INTERP: begin
                     if (span < ADDR_W'(2)) begin
                        fin        = 1'b1;
                        fin_status = STATUS_SHORT;
                     end else begin
                        state_in = ST_IP_RD;
                     end
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_XP: begin
            if ((cnt_ff <= {1'b0, hi_ff}) && (dst_ff < ENTRIES_C)) begin
               undo_raddr  = cnt_ff[ADDR_W-1:0];
               pend_in     = 1'b1;
               pend_dst_in = dst_ff[ADDR_W-1:0];
               cnt_in      = cnt_ff + 1'b1;
               dst_in      = dst_ff + 1'b1;
            end else begin
               fin = 1'b1;
            end
         end
         ST_INC_RD: begin
            undo_raddr = lo_ff;
            state_in   = ST_INC_SEED;
         end
         ST_INC_SEED: begin
            v_in     = undo_rdata;
            cnt_in   = {1'b0, lo_ff} + 1'b1;
            state_in = ST_INC;
         end
         ST_INC: begin
            pitch_we    = 1'b1;
            pitch_waddr = cnt_ff[ADDR_W-1:0];
            pitch_wdata = inc_value;
            v_in        = inc_value;
            if (cnt_ff == {1'b0, hi_ff}) begin
               fin = 1'b1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IP_RD: begin
            undo_raddr  = lo_ff;
            pitch_raddr = hi_ff;
            state_in    = ST_IP_DIV;
         end
         ST_IP_DIV: begin
            div_start = 1'b1;
            neg_in    = diff[VALUE_W];
            v_in      = undo_rdata;
            state_in  = ST_IP_WAIT;
         end
         ST_IP_WAIT: begin
            if (div_done) begin
               slope_in = neg_ff ? SLOPE_W'(0) - div_quotient : div_quotient;
               acc_in   = neg_ff ? SLOPE_W'(0) - div_quotient : div_quotient;
               cnt_in   = {1'b0, lo_ff} + 1'b1;
               state_in = ST_IP_FILL;
            end
         end
         ST_IP_FILL: begin
            pitch_we    = 1'b1;
            pitch_waddr = cnt_ff[ADDR_W-1:0];
            pitch_wdata = acc_ff[SLOPE_W-1:FRAC_W] + v_ff;
            acc_in      = acc_ff + slope_ff;
            if (cnt_ff == hi_dec) begin
               fin = 1'b1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
      endcase

      if (fin) begin
         state_in                = ST_IDLE;
         rsp_strobe_in           = 1'b1;
         rsp_data_in.read_value  = fin_value;
         rsp_data_in.status      = fin_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      d_ff        <= d_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      wv_ff       <= wv_in;
      dst_ff      <= dst_in;
      pend_dst_ff <= pend_dst_in;
      v_ff        <= v_in;
      slope_ff    <= slope_in;
      acc_ff      <= acc_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire

// ----- dv/tuning_table_edit_engine_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for tuning_table_edit_engine_core: a queue-fed command driver, a result
// monitor and a behavioural copy of the pitch and undo tables that predicts every result.
// Depends on tte_pkg and the core RTL.

module tuning_table_edit_engine_core_tb;
   import tte_pkg::*;

   localparam int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES;
   localparam int CLK_HALF      = 6;
   localparam int RESET_CYCLES  = 11;
   localparam int MAX_GAP       = 16;
   localparam int DRAIN_CYCLES  = 2 * TABLE_ENTRIES + 40;

   localparam logic [OP_W-1:0]        OP_RSVD5  = 3'd5;
   localparam logic [OP_W-1:0]        OP_RSVD6  = 3'd6;
   localparam logic [OP_W-1:0]        OP_RSVD7  = 3'd7;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   start      = 1'b0;
   req_type                req_data   = '0;
   logic                   busy;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   tuning_table_edit_engine_core #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // table model and its settings
   logic signed [VALUE_W-1:0] pitch_tbl [TABLE_ENTRIES];
   logic signed [VALUE_W-1:0] undo_tbl  [TABLE_ENTRIES];
   logic signed [VALUE_W-1:0] step_cfg = STEP_RESET;
   logic [LIMIT_W-1:0]        max_cfg  = PITCH_MAX_RESET;
   logic [LIMIT_W-1:0]        min_cfg  = PITCH_MIN_RESET;

   req_type    cmd_queue   [$];
   rsp_type    rsp_awaited [$];
   int         gap_max       = MAX_GAP;
   logic [4:0] wait_cnt      = '0;
   int         fail_count    = 0;
   int         short_count   = 0;
   int         setting_count = 1;
   int         op_count [8]  = '{default: 0};

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("run timed out with %0d results outstanding", rsp_awaited.size());
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int clamp_pitch(int v);
      if (v > int'(max_cfg)) return int'(max_cfg);
      if (v < int'(min_cfg)) return int'(min_cfg);
      return v;
   endfunction

   function automatic rsp_type run_command(req_type c);
      rsp_type r;
      int      a, b, d, lo, hi, i, n, v;
      longint  base, slope, p;
      r        = '0;
      r.status = STATUS_OK;
      a  = int'(c.first_key) % TABLE_ENTRIES;
      b  = int'(c.second_key) % TABLE_ENTRIES;
      d  = int'(c.dest_key) % TABLE_ENTRIES;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      case (c.op)
         OP_READ: r.read_value = pitch_tbl[a];
         OP_WRITE: pitch_tbl[a] = c.write_value;
         OP_TRANSPOSE, OP_INCREMENT, OP_INTERP: begin
            undo_tbl = pitch_tbl;
            if (c.op == OP_TRANSPOSE) begin
               // stop at the table end
               for (i = lo; i <= hi && d < TABLE_ENTRIES; i++) begin
                  pitch_tbl[d] = VALUE_W'(clamp_pitch(int'(undo_tbl[i]) + int'(step_cfg)));
                  d++;
               end
            end else if (c.op == OP_INCREMENT) begin
               if (lo == hi) begin
                  r.status = STATUS_SHORT;
               end else begin
                  v = int'(undo_tbl[lo]);
                  for (i = lo + 1; i <= hi; i++) begin
                     v            = clamp_pitch(v + int'(step_cfg));
                     pitch_tbl[i] = VALUE_W'(v);
                  end
               end
            end else begin
               n = hi - lo;
               if (n < 2) begin
                  r.status = STATUS_SHORT;
               end else begin
                  base  = longint'(pitch_tbl[lo]);
                  slope = ((longint'(pitch_tbl[hi]) - base) <<< FRAC_W) / longint'(n);
                  for (i = 1; i < n; i++) begin
                     p                 = ((slope * longint'(i)) >>> FRAC_W) + base;
                     pitch_tbl[lo + i] = VALUE_W'(p);
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic req_type random_cmd();
      req_type c;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         c.op = OP_READ;
      end else if (pick < 50) begin
         c.op = OP_WRITE;
      end else if (pick < 64) begin
         c.op = OP_TRANSPOSE;
      end else if (pick < 78) begin
         c.op = OP_INCREMENT;
      end else if (pick < 95) begin
         c.op = OP_INTERP;
      end else begin
         case ($urandom_range(0, 2))
            0: c.op = OP_RSVD5;
            1: c.op = OP_RSVD6;
            default: c.op = OP_RSVD7;
         endcase
      end
      c.first_key = KEY_W'($urandom);
      c.dest_key  = KEY_W'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         c.second_key = c.first_key + KEY_W'($urandom_range(0, 3));
      end else begin
         c.second_key = KEY_W'($urandom);
      end
      case ($urandom_range(0, 3))
         0: c.write_value = VALUE_W'($urandom);
         1, 2: c.write_value = VALUE_W'($urandom_range(0, 32767));
         default: begin
            case ($urandom_range(0, 2))
               0: c.write_value = 16'sh8000;
               1: c.write_value = 16'sh7fff;
               default: c.write_value = '1;
            endcase
         end
      endcase
      return c;
   endfunction

   task automatic queue_cmd(input logic [OP_W-1:0] op, input int a, input int b, input int d,
                            input logic signed [VALUE_W-1:0] wv);
      req_type c;
      c.op          = op;
      c.first_key   = KEY_W'(a);
      c.second_key  = KEY_W'(b);
      c.dest_key    = KEY_W'(d);
      c.write_value = wv;
      cmd_queue.push_back(c);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (cmd_queue.size() != 0 || start || rsp_awaited.size() != 0 || busy);
   endtask

   task automatic run_batch(input int count);
      repeat (count) cmd_queue.push_back(random_cmd());
      wait_idle();
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_STEP_VALUE: step_cfg = data;
         CSR_PITCH_MAX:  max_cfg  = data[LIMIT_W-1:0];
         CSR_PITCH_MIN:  min_cfg  = data[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   // command driver: hold each transfer until busy drops, then draw the gap to the next
   always @(posedge clock) begin
      int unsigned gap;
      if (reset) begin
         start    <= 1'b0;
         wait_cnt <= '0;
      end else if (start && !busy) begin
         rsp_awaited.push_back(run_command(req_data));
         op_count[req_data.op]++;
         gap = $urandom_range(0, gap_max);
         if (gap == 0 && cmd_queue.size() != 0) begin
            req_data <= cmd_queue.pop_front();
         end else begin
            start    <= 1'b0;
            wait_cnt <= 5'(gap);
         end
      end else if (!start) begin
         if (wait_cnt != 0) begin
            wait_cnt <= wait_cnt - 1'b1;
         end else if (cmd_queue.size() != 0) begin
            req_data <= cmd_queue.pop_front();
            start    <= 1'b1;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (rsp_awaited.size() == 0) begin
            $error("result transfer with none outstanding: read_value %0d status %0d",
                   rsp_data.read_value, rsp_data.status);
            fail_count++;
         end else begin
            want = rsp_awaited.pop_front();
            if (rsp_data.read_value !== want.read_value) begin
               $error("read_value mismatch: expected %0d, got %0d",
                      want.read_value, rsp_data.read_value);
               fail_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status mismatch: expected %0d, got %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.status === STATUS_SHORT) short_count++;
         end
      end
   end

   initial begin
      cfg_type s;
      int      k;
      for (k = 0; k < TABLE_ENTRIES; k++) begin
         if (k < ET_LOW_KEY) begin
            pitch_tbl[k] = VALUE_W'(2 * ET_FLOOR_HC);
         end else if (k > ET_HIGH_KEY) begin
            pitch_tbl[k] = VALUE_W'(2 * ET_CEIL_HC);
         end else begin
            pitch_tbl[k] = VALUE_W'(2 * (ET_FLOOR_HC + (k - ET_REF_KEY) * ET_SEMITONE_HC));
         end
         undo_tbl[k] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // directed commands at the reset settings
      queue_cmd(OP_READ, 0, 0, 0, '0);
      queue_cmd(OP_READ, 127, 0, 0, '0);
      queue_cmd(OP_READ, 69, 0, 0, '0);
      queue_cmd(OP_WRITE, 127, 0, 0, 16'sh7fff);
      queue_cmd(OP_WRITE, 0, 0, 0, 16'sh8000);
      queue_cmd(OP_READ, 127, 0, 0, '0);
      queue_cmd(OP_READ, 0, 0, 0, '0);
      queue_cmd(OP_TRANSPOSE, 20, 10, 120, '0);
      queue_cmd(OP_READ, 127, 0, 0, '0);
      queue_cmd(OP_INCREMENT, 50, 50, 0, '0);
      queue_cmd(OP_INCREMENT, 127, 0, 0, '0);
      queue_cmd(OP_READ, 64, 0, 0, '0);
      queue_cmd(OP_INTERP, 5, 6, 0, '0);
      queue_cmd(OP_INTERP, 9, 9, 0, '0);
      queue_cmd(OP_WRITE, 30, 0, 0, 16'sh8000);
      queue_cmd(OP_WRITE, 40, 0, 0, 16'sh7fff);
      queue_cmd(OP_INTERP, 40, 30, 0, '0);
      queue_cmd(OP_READ, 35, 0, 0, '0);
      queue_cmd(OP_INTERP, 0, 127, 0, '0);
      queue_cmd(OP_READ, 1, 0, 0, '0);
      queue_cmd(OP_RSVD5, $urandom_range(0, 127), $urandom_range(0, 127), 0, VALUE_W'($urandom));
      queue_cmd(OP_RSVD6, $urandom_range(0, 127), $urandom_range(0, 127), 0, VALUE_W'($urandom));
      queue_cmd(OP_RSVD7, $urandom_range(0, 127), $urandom_range(0, 127), 0, VALUE_W'($urandom));
      queue_cmd(OP_READ, 126, 0, 0, '0);
      queue_cmd(OP_TRANSPOSE, 0, 127, 0, '0);
      wait_idle();
      run_batch(150);

      for (k = 0; k < 7; k++) begin
         case (k)
            0: s = '{step_value: 16'sd19998, pitch_max: 15'd32767, pitch_min: 15'd0};
            1: s = '{step_value: -16'sd19998, pitch_max: 15'd32767, pitch_min: 15'd0};
            2: s = '{step_value: -16'sd19998, pitch_max: 15'd0, pitch_min: 15'd0};
            3: s = '{step_value: 16'sd19998, pitch_max: 15'd0, pitch_min: 15'd32767};
            4: s = '{step_value: 16'sd1, pitch_max: 15'd32767, pitch_min: 15'd32767};
            5: begin
               s.step_value = VALUE_W'($urandom_range(0, 39996) - 19998);
               s.pitch_min  = LIMIT_W'($urandom_range(0, 16000));
               s.pitch_max  = LIMIT_W'($urandom_range(16000, 32767));
            end
            default: begin
               s.step_value = VALUE_W'($urandom_range(0, 39996) - 19998);
               s.pitch_min  = LIMIT_W'($urandom);
               s.pitch_max  = LIMIT_W'($urandom);
            end
         endcase
         csr_write(CSR_STEP_VALUE, s.step_value);
         csr_write(CSR_PITCH_MAX, {1'($urandom_range(0, 1)), s.pitch_max});
         csr_write(CSR_PITCH_MIN, {1'($urandom_range(0, 1)), s.pitch_min});
         if (k == 3) csr_write(CSR_SPARE, CSR_DATA_W'($urandom));
         setting_count++;
         @(negedge clock);
         gap_max = (k % 2 == 1) ? 0 : MAX_GAP;
         run_batch(125);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d reads, %0d writes, %0d transposes, %0d increments, %0d interpolations",
               op_count[OP_READ], op_count[OP_WRITE], op_count[OP_TRANSPOSE],
               op_count[OP_INCREMENT], op_count[OP_INTERP]);
      $display("and %0d undefined commands over %0d register settings; %0d short intervals seen",
               op_count[OP_RSVD5] + op_count[OP_RSVD6] + op_count[OP_RSVD7], setting_count,
               short_count);
      if (fail_count == 0 && rsp_awaited.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
